// ----- sv/dqs_pkg.sv -----
// Shared types and constants for the deque-with-search block.
// No dependencies; used by dqs_front, dqs_back and deque_with_search.
package dqs_pkg;

    localparam int DATA_W        = 32;
    localparam int OPCODE_W      = 3;
    localparam int STATUS_W      = 2;
    localparam int POS_W         = 4;
    localparam int DEPTH_DEFAULT = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OPCODE_W-1:0] OPC_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OPC_PUSH_BACK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OPC_SEARCH     = 3'd2;
    localparam logic [OPCODE_W-1:0] OPC_POP_FRONT  = 3'd3;
    localparam logic [OPCODE_W-1:0] OPC_LIST       = 3'd4;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT,
        CMD_PUSH_BACK,
        CMD_SEARCH,
        CMD_POP_FRONT,
        CMD_LIST
    } cmd_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_POP,
        BK_WALK
    } back_state_t;

    typedef struct packed {
        cmd_op_t                  op;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

endpackage

// ----- sv/dqs_front.sv -----
// Input side: accepts requests, decodes the opcode, drops unused codes and
// queues commands for the execution side. Depends on dqs_pkg.
module dqs_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [dqs_pkg::OPCODE_W-1:0]         s_opcode,
    input  logic signed [dqs_pkg::DATA_W-1:0]    s_value,
    output logic                                 cmd_valid,
    input  logic                                 cmd_ready,
    output dqs_pkg::cmd_t                        cmd
);

    dqs_pkg::cmd_t                   q_mem [dqs_pkg::QUEUE_DEPTH];
    logic [dqs_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [dqs_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [dqs_pkg::QUEUE_CW-1:0]    q_count_reg, q_count_next;
    logic                            op_ok;
    dqs_pkg::cmd_op_t                op_dec;
    logic                            push, pop;

    always_comb begin
        op_ok  = 1'b1;
        op_dec = dqs_pkg::CMD_PUSH_FRONT;
        unique case (s_opcode)
            dqs_pkg::OPC_PUSH_FRONT: op_dec = dqs_pkg::CMD_PUSH_FRONT;
            dqs_pkg::OPC_PUSH_BACK:  op_dec = dqs_pkg::CMD_PUSH_BACK;
            dqs_pkg::OPC_SEARCH:     op_dec = dqs_pkg::CMD_SEARCH;
            dqs_pkg::OPC_POP_FRONT:  op_dec = dqs_pkg::CMD_POP_FRONT;
            dqs_pkg::OPC_LIST:       op_dec = dqs_pkg::CMD_LIST;
            default:                 op_ok  = 1'b0;
        endcase
    end

    assign s_ready   = (q_count_reg != dqs_pkg::QUEUE_CW'(dqs_pkg::QUEUE_DEPTH));
    assign cmd_valid = (q_count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign push      = s_valid && s_ready && op_ok;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        q_count_next = q_count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == dqs_pkg::QUEUE_AW'(dqs_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == dqs_pkg::QUEUE_AW'(dqs_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   q_count_next = q_count_reg + 1'b1;
            2'b01:   q_count_next = q_count_reg - 1'b1;
            default: q_count_next = q_count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end else begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            q_count_reg <= q_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= '{op: op_dec, value: s_value};
        end
    end

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count_reg <= dqs_pkg::QUEUE_CW'(dqs_pkg::QUEUE_DEPTH))
        else $error("command queue count out of range");

endmodule

// ----- sv/dqs_back.sv -----
// Execution side: ring store, front index and entry count, the command
// sequencer and the result register. Depends on dqs_pkg.
module dqs_back #(
    parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cmd_valid,
    output logic                                 cmd_ready,
    input  dqs_pkg::cmd_t                        cmd,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [dqs_pkg::STATUS_W-1:0]         m_status,
    output logic signed [dqs_pkg::DATA_W-1:0]    m_data,
    output logic [dqs_pkg::POS_W-1:0]            m_position,
    output logic                                 m_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return AW'(sum);
    endfunction

    logic signed [dqs_pkg::DATA_W-1:0] store_mem [DEPTH];
    logic signed [dqs_pkg::DATA_W-1:0] rd_data_reg;

    dqs_pkg::back_state_t              state_reg, state_next;
    logic [AW-1:0]                     front_reg, front_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [CW-1:0]                     cur_reg, cur_next;
    logic                              search_reg, search_next;
    logic signed [dqs_pkg::DATA_W-1:0] key_reg, key_next;

    logic                              m_valid_reg, m_valid_next;
    dqs_pkg::status_t                  m_status_reg, m_status_next;
    logic signed [dqs_pkg::DATA_W-1:0] m_data_reg, m_data_next;
    logic [dqs_pkg::POS_W-1:0]         m_position_reg, m_position_next;
    logic                              m_last_reg, m_last_next;

    logic                              out_free;
    logic                              emit;
    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    logic [CW-1:0]                     rd_off;
    logic [AW-1:0]                     rd_addr;
    logic [AW-1:0]                     front_dec;
    logic [CW-1:0]                     cur_inc;
    logic                              at_end;
    logic                              is_full, is_empty;

    assign out_free  = !m_valid_reg || m_ready;
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - 1'b1;
    assign cur_inc   = cur_reg + 1'b1;
    assign at_end    = (cur_inc == count_reg);
    assign is_full   = (count_reg == FULL_C);
    assign is_empty  = (count_reg == '0);
    assign rd_addr   = slot(front_reg, rd_off);

    always_comb begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        search_next     = search_reg;
        key_next        = key_reg;
        cmd_ready       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = front_dec;
        rd_off          = '0;
        emit            = 1'b0;
        m_status_next   = dqs_pkg::ST_OK;
        m_data_next     = '0;
        m_position_next = '0;
        m_last_next     = 1'b1;

        unique case (state_reg)
            dqs_pkg::BK_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_ready = 1'b1;
                    cur_next  = '0;
                    key_next  = cmd.value;
                    case (cmd.op)
                        dqs_pkg::CMD_PUSH_FRONT: begin
                            emit = 1'b1;
                            if (is_full) begin
                                m_status_next = dqs_pkg::ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = front_dec;
                                front_next = front_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        dqs_pkg::CMD_PUSH_BACK: begin
                            emit = 1'b1;
                            if (is_full) begin
                                m_status_next = dqs_pkg::ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = slot(front_reg, count_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        dqs_pkg::CMD_POP_FRONT: begin
                            if (is_empty) begin
                                emit          = 1'b1;
                                m_status_next = dqs_pkg::ST_EMPTY;
                            end else begin
                                state_next = dqs_pkg::BK_POP;
                            end
                        end
                        dqs_pkg::CMD_SEARCH: begin
                            search_next = 1'b1;
                            if (is_empty) begin
                                emit          = 1'b1;
                                m_status_next = dqs_pkg::ST_NOTFOUND;
                            end else begin
                                state_next = dqs_pkg::BK_WALK;
                            end
                        end
                        dqs_pkg::CMD_LIST: begin
                            search_next = 1'b0;
                            if (is_empty) begin
                                emit          = 1'b1;
                                m_status_next = dqs_pkg::ST_EMPTY;
                            end else begin
                                state_next = dqs_pkg::BK_WALK;
                            end
                        end
                        default: cmd_ready = 1'b1;
                    endcase
                end
            end
            dqs_pkg::BK_POP: begin
                if (out_free) begin
                    emit        = 1'b1;
                    m_data_next = rd_data_reg;
                    front_next  = slot(front_reg, CW'(1));
                    count_next  = count_reg - 1'b1;
                    state_next  = dqs_pkg::BK_IDLE;
                end
            end
            dqs_pkg::BK_WALK: begin
                rd_off = cur_reg;
                if (out_free) begin
                    rd_off   = cur_inc;
                    cur_next = cur_inc;
                    if (search_reg) begin
                        if (rd_data_reg == key_reg) begin
                            emit            = 1'b1;
                            m_data_next     = rd_data_reg;
                            m_position_next = dqs_pkg::POS_W'(cur_reg);
                            state_next      = dqs_pkg::BK_IDLE;
                        end else if (at_end) begin
                            emit          = 1'b1;
                            m_status_next = dqs_pkg::ST_NOTFOUND;
                            state_next    = dqs_pkg::BK_IDLE;
                        end
                    end else begin
                        emit            = 1'b1;
                        m_data_next     = rd_data_reg;
                        m_position_next = dqs_pkg::POS_W'(cur_reg);
                        m_last_next     = at_end;
                        if (at_end) begin
                            state_next = dqs_pkg::BK_IDLE;
                        end
                    end
                end
            end
            default: state_next = dqs_pkg::BK_IDLE;
        endcase

        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dqs_pkg::BK_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            cur_reg     <= '0;
            search_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            cur_reg     <= cur_next;
            search_reg  <= search_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (emit) begin
            m_status_reg   <= m_status_next;
            m_data_reg     <= m_data_next;
            m_position_reg <= m_position_next;
            m_last_reg     <= m_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= cmd.value;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_data     = m_data_reg;
    assign m_position = m_position_reg;
    assign m_last     = m_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_C)
        else $error("entry count above depth");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == dqs_pkg::BK_WALK |-> cur_reg < count_reg)
        else $error("walk offset beyond stored entries");

    a_walk_holds_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == dqs_pkg::BK_WALK |=> $stable(count_reg) && $stable(front_reg))
        else $error("store changed during walk");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == dqs_pkg::BK_POP |-> count_reg != '0)
        else $error("pop sequenced on empty store");

endmodule

// ----- sv/deque_with_search.sv -----
// A push, pop or empty/full response passes the command queue, then the result register;
// a pop also passes the BK_POP state and the store read register; search and list
// walk the ring store one entry per cycle while the output is free.
// The execution side takes one command at a time: one push or empty/full response per cycle
// while the output is free; a pop or walk holds later commands; 2-entry command queue.
// Reset (aresetn low, synchronous) empties the deque; store contents are not cleared.
module deque_with_search #(
    parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [dqs_pkg::OPCODE_W-1:0]         s_opcode,
    input  logic signed [dqs_pkg::DATA_W-1:0]    s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [dqs_pkg::STATUS_W-1:0]         m_status,
    output logic signed [dqs_pkg::DATA_W-1:0]    m_data,
    output logic [dqs_pkg::POS_W-1:0]            m_position,
    output logic                                 m_last
);

    logic          cmd_valid;
    logic          cmd_ready;
    dqs_pkg::cmd_t cmd;

    dqs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_opcode  (s_opcode),
        .s_value   (s_value),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    dqs_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_data     (m_data),
        .m_position (m_position),
        .m_last     (m_last)
    );

endmodule
